### sv/pnms_pkg.sv
package pnms_pkg;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_MROW_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MROW_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MROW_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LDIR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TINT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND = 3'd5;

   // register reset values
   localparam logic [47:0] MROW_X_RST = 48'h0000_0000_1000;
   localparam logic [47:0] MROW_Y_RST = 48'h0000_1000_0000;
   localparam logic [47:0] MROW_Z_RST = 48'h1000_0000_0000;
   localparam logic [47:0] LDIR_RST = 48'h1000_0000_0000;
   localparam logic [47:0] TINT_RST = 48'h1000_1000_1000;
   localparam logic [63:0] BLEND_RST = 64'h0;

   // pipeline depths
   localparam int SQRT_STEPS = 30;
   localparam int DIV_STEPS = 13;
   localparam int LOG_STEPS = 16;
   localparam int EXP_STEPS = 16;
   localparam int QUEUE_AW = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // floor(2^36/255), for the exponent scaling
   localparam logic [28:0] RECIP_255 = 29'h1010_1010;

   typedef struct packed {
      logic [7:0] normal_red;
      logic [7:0] normal_green;
      logic [7:0] normal_blue;
      logic [7:0] specular_level;
      logic [7:0] base_red;
      logic [7:0] base_green;
      logic [7:0] base_blue;
      logic [7:0] base_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] shaded_red;
      logic [7:0] shaded_green;
      logic [7:0] shaded_blue;
      logic [7:0] shaded_alpha;
      logic       normal_degenerate;
   } rsp_type;

   // word passed from the geometry front to the lighting back
   typedef struct packed {
      logic signed [13:0] u_x;
      logic signed [13:0] u_y;
      logic signed [13:0] u_z;
      logic               degen;
      req_type            px;
   } geo_type;

   typedef logic [255:0][13:0] nmap_type;
   typedef logic [EXP_STEPS-1:0][29:0] root_tbl_type;

   // texel code to signed q12 normal lane
   function automatic nmap_type build_nmap();
      nmap_type tb;
      int m;
      int q;
      for (int c = 0; c < 256; c++) begin
         m = 2 * c - 255;
         if (m < 0) begin
            q = ((-m) * 8192 + 255) / 510;
            tb[c] = 14'(-q);
         end else begin
            q = (m * 8192 + 255) / 510;
            tb[c] = 14'(q);
         end
      end
      return tb;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] b;
      rem = v;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // repeated floored square roots of one half, q30
   function automatic root_tbl_type build_roots();
      root_tbl_type tb;
      logic [63:0] r;
      r = 64'd1 << 29;
      for (int i = 0; i < EXP_STEPS; i++) begin
         if (i > 0) begin
            r = isqrt64(r << 30);
         end
         tb[i] = r[29:0];
      end
      return tb;
   endfunction

   localparam nmap_type NMAP = build_nmap();
   localparam root_tbl_type EXP_ROOT = build_roots();

endpackage

### sv/pnms_front.sv
module pnms_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pnms_pkg::req_type   in_data,
   input  logic [47:0]         mrow_x,
   input  logic [47:0]         mrow_y,
   input  logic [47:0]         mrow_z,
   output logic                out_valid,
   output pnms_pkg::geo_type   out_data
);

   localparam int SQ = pnms_pkg::SQRT_STEPS;
   localparam int DV = pnms_pkg::DIV_STEPS;

   logic [47:0] mrow [3];
   assign mrow[0] = mrow_x;
   assign mrow[1] = mrow_y;
   assign mrow[2] = mrow_z;

   // texel to normal lanes
   logic               a_vld_ff;
   logic signed [13:0] a_n_ff [3];
   pnms_pkg::req_type  a_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_n_ff[0] <= pnms_pkg::NMAP[in_data.normal_red];
      a_n_ff[1] <= pnms_pkg::NMAP[in_data.normal_green];
      a_n_ff[2] <= pnms_pkg::NMAP[in_data.normal_blue];
      a_px_ff <= in_data;
   end

   // matrix products
   logic               b_vld_ff;
   logic signed [29:0] b_prod_ff [3][3];
   pnms_pkg::req_type  b_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            b_prod_ff[i][j] <= 30'($signed(mrow[i][16*j +: 16]) * a_n_ff[j]);
         end
      end
      b_px_ff <= a_px_ff;
   end

   // row sums
   logic               c_vld_ff;
   logic signed [29:0] c_t_ff [3];
   pnms_pkg::req_type  c_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         c_t_ff[i] <= b_prod_ff[i][0] + b_prod_ff[i][1] + b_prod_ff[i][2];
      end
      c_px_ff <= b_px_ff;
   end

   // squares
   logic               d_vld_ff;
   logic [57:0]        d_sq_ff [3];
   logic signed [29:0] d_t_ff [3];
   pnms_pkg::req_type  d_px_ff;
   logic [29:0]        c_abs [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_abs[i] = c_t_ff[i][29] ? 30'(-c_t_ff[i]) : 30'(c_t_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d_sq_ff[i] <= c_abs[i][28:0] * c_abs[i][28:0];
      end
      d_t_ff <= c_t_ff;
      d_px_ff <= c_px_ff;
   end

   // square root, one result bit a stage; element 0 holds the length squared
   logic               sq_vld_ff [SQ+1];
   logic [59:0]        sq_rem_ff [SQ+1];
   logic [59:0]        sq_root_ff [SQ+1];
   logic signed [29:0] sq_t_ff [SQ+1][3];
   pnms_pkg::req_type  sq_px_ff [SQ+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_rem_ff[0] <= 60'(d_sq_ff[0]) + 60'(d_sq_ff[1]) + 60'(d_sq_ff[2]);
      sq_root_ff[0] <= '0;
      sq_t_ff[0] <= d_t_ff;
      sq_px_ff[0] <= d_px_ff;
   end

   for (genvar j = 1; j <= SQ; j++) begin : g_sqrt
      localparam logic [59:0] SQ_ONE = 60'd1 << (60 - 2 * j);
      logic [59:0] trial;
      assign trial = sq_root_ff[j-1] + SQ_ONE;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j] <= 1'b0;
         end else begin
            sq_vld_ff[j] <= sq_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (sq_rem_ff[j-1] >= trial) begin
            sq_rem_ff[j] <= sq_rem_ff[j-1] - trial;
            sq_root_ff[j] <= (sq_root_ff[j-1] >> 1) + SQ_ONE;
         end else begin
            sq_rem_ff[j] <= sq_rem_ff[j-1];
            sq_root_ff[j] <= sq_root_ff[j-1] >> 1;
         end
         sq_t_ff[j] <= sq_t_ff[j-1];
         sq_px_ff[j] <= sq_px_ff[j-1];
      end
   end

   // rounded divide by the length, three lanes, one quotient bit a stage
   logic               dv_vld_ff [DV+1];
   logic [43:0]        dv_rem_ff [DV+1][3];
   logic [12:0]        dv_quo_ff [DV+1][3];
   logic [2:0]         dv_neg_ff [DV+1];
   logic [30:0]        dv_den_ff [DV+1];
   logic               dv_degen_ff [DV+1];
   pnms_pkg::req_type  dv_px_ff [DV+1];
   logic [29:0]        len;
   logic [29:0]        s_abs [3];

   assign len = sq_root_ff[SQ][29:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_abs[i] = sq_t_ff[SQ][i][29] ? 30'(-sq_t_ff[SQ][i]) : 30'(sq_t_ff[SQ][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[SQ];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= 44'({s_abs[i][28:0], 13'd0}) + 44'(len);
         dv_quo_ff[0][i] <= '0;
         dv_neg_ff[0][i] <= sq_t_ff[SQ][i][29];
      end
      dv_den_ff[0] <= {len, 1'b0};
      dv_degen_ff[0] <= (len == '0);
      dv_px_ff[0] <= sq_px_ff[SQ];
   end

   for (genvar k = 1; k <= DV; k++) begin : g_div
      logic [43:0] dsh;
      assign dsh = 44'(dv_den_ff[k-1]) << (DV - k);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[k-1][i] >= dsh) begin
               dv_rem_ff[k][i] <= dv_rem_ff[k-1][i] - dsh;
               dv_quo_ff[k][i] <= {dv_quo_ff[k-1][i][11:0], 1'b1};
            end else begin
               dv_rem_ff[k][i] <= dv_rem_ff[k-1][i];
               dv_quo_ff[k][i] <= {dv_quo_ff[k-1][i][11:0], 1'b0};
            end
         end
         dv_neg_ff[k] <= dv_neg_ff[k-1];
         dv_den_ff[k] <= dv_den_ff[k-1];
         dv_degen_ff[k] <= dv_degen_ff[k-1];
         dv_px_ff[k] <= dv_px_ff[k-1];
      end
   end

   // signed unit normal out
   logic signed [13:0] u [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_degen_ff[DV]) begin
            u[i] = '0;
         end else if (dv_neg_ff[DV][i]) begin
            u[i] = 14'(-{1'b0, dv_quo_ff[DV][i]});
         end else begin
            u[i] = 14'({1'b0, dv_quo_ff[DV][i]});
         end
      end
   end

   assign out_valid = dv_vld_ff[DV];
   assign out_data.u_x = u[0];
   assign out_data.u_y = u[1];
   assign out_data.u_z = u[2];
   assign out_data.degen = dv_degen_ff[DV];
   assign out_data.px = dv_px_ff[DV];

endmodule

### sv/pnms_queue.sv
module pnms_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pnms_pkg::geo_type  push_data,
   output logic               pop_valid,
   output pnms_pkg::geo_type  pop_data,
   output logic               full
);

   localparam int AW = pnms_pkg::QUEUE_AW;

   pnms_pkg::geo_type mem [pnms_pkg::QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff;
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW:0]       cnt_ff;
   logic              pop_valid_ff;
   pnms_pkg::geo_type pop_data_ff;
   logic              pop;

   // the back end takes a word every cycle
   assign pop = (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
         pop_valid_ff <= pop;
      end
   end

   assign pop_valid = pop_valid_ff;
   assign pop_data = pop_data_ff;
   assign full = (cnt_ff == (AW+1)'(pnms_pkg::QUEUE_DEPTH));

endmodule

### sv/pnms_back.sv
module pnms_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  pnms_pkg::geo_type  in_data,
   input  logic [47:0]        ldir,
   input  logic [47:0]        tint,
   input  logic [63:0]        blend,
   output logic               rsp_valid,
   output pnms_pkg::rsp_type  rsp_data
);

   localparam int LG = pnms_pkg::LOG_STEPS;
   localparam int EX = pnms_pkg::EXP_STEPS;

   typedef struct packed {
      logic [16:0]       diff;
      logic [20:0]       p;
      logic              one;
      logic              zero;
      logic              degen;
      pnms_pkg::req_type px;
   } cy_type;

   logic [15:0] amb;
   logic [15:0] dratio;
   logic [15:0] sratio;
   logic [15:0] mult;
   assign amb = blend[15:0];
   assign dratio = blend[31:16];
   assign sratio = blend[47:32];
   assign mult = blend[63:48];

   // dot products with the light, exponent product
   logic               b1_vld_ff;
   logic signed [29:0] b1_prod_ff [3];
   logic [23:0]        b1_pm_ff;
   pnms_pkg::geo_type  b1_g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
      end else begin
         b1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      b1_prod_ff[0] <= 30'(in_data.u_x * $signed(ldir[15:0]));
      b1_prod_ff[1] <= 30'(in_data.u_y * $signed(ldir[31:16]));
      b1_prod_ff[2] <= 30'(in_data.u_z * $signed(ldir[47:32]));
      b1_pm_ff <= in_data.px.specular_level * mult;
      b1_g_ff <= in_data;
   end

   // n.l sum, exponent divide by 255 estimate
   logic               b2_vld_ff;
   logic signed [30:0] b2_d_ff;
   logic [28:0]        b2_x_ff;
   logic [20:0]        b2_q0_ff;
   pnms_pkg::geo_type  b2_g_ff;
   logic [28:0]        x_in;
   logic [57:0]        xr;

   assign x_in = 29'({b1_pm_ff, 4'd0}) + 29'd127;
   assign xr = x_in * pnms_pkg::RECIP_255;

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_vld_ff <= 1'b0;
      end else begin
         b2_vld_ff <= b1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b2_d_ff <= 31'(b1_prod_ff[0]) + 31'(b1_prod_ff[1]) + 31'(b1_prod_ff[2]);
      b2_x_ff <= x_in;
      b2_q0_ff <= xr[56:36];
      b2_g_ff <= b1_g_ff;
   end

   // reflection product, diffuse, exponent correction
   logic               b3_vld_ff;
   logic signed [44:0] b3_du_ff;
   cy_type             b3_cy_ff;
   logic [28:0]        q255;
   logic [29:0]        qrem;
   logic [30:0]        dround;

   assign q255 = {b2_q0_ff, 8'd0} - 29'(b2_q0_ff);
   assign qrem = 30'(b2_x_ff) - 30'(q255);
   assign dround = b2_d_ff + 31'sd2048;

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_vld_ff <= 1'b0;
      end else begin
         b3_vld_ff <= b2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b3_du_ff <= 45'(b2_d_ff * b2_g_ff.u_z);
      b3_cy_ff.diff <= (b2_d_ff > 0) ? dround[28:12] : '0;
      b3_cy_ff.p <= b2_q0_ff + 21'(qrem >= 30'd255);
      b3_cy_ff.one <= 1'b0;
      b3_cy_ff.zero <= 1'b0;
      b3_cy_ff.degen <= b2_g_ff.degen;
      b3_cy_ff.px <= b2_g_ff.px;
   end

   // specular base from rz
   logic               b4_vld_ff;
   logic [16:0]        b4_base_ff;
   cy_type             b4_cy_ff;
   logic signed [45:0] rz;
   logic [45:0]        rz_rnd;

   assign rz = (46'(b3_du_ff) <<< 1) - (46'($signed(ldir[47:32])) <<< 24);
   assign rz_rnd = 46'(rz) + (46'd1 << 19);

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_vld_ff <= 1'b0;
      end else begin
         b4_vld_ff <= b3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rz[45] || rz == '0) begin
         b4_base_ff <= '0;
      end else if (rz[44:36] != '0) begin
         b4_base_ff <= 17'h10000;
      end else begin
         b4_base_ff <= rz_rnd[36:20];
      end
      b4_cy_ff <= b3_cy_ff;
   end

   // normalize base; element 0 of the log chain
   logic        lg_vld_ff [LG+1];
   logic [30:0] lg_y_ff [LG+1];
   logic [15:0] lg_frac_ff [LG+1];
   logic [3:0]  lg_n_ff [LG+1];
   cy_type      lg_cy_ff [LG+1];
   logic [3:0]  nsh;

   always_comb begin
      nsh = '0;
      for (int i = 0; i < 16; i++) begin
         if (b4_base_ff[i]) begin
            nsh = 4'(15 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_vld_ff[0] <= 1'b0;
      end else begin
         lg_vld_ff[0] <= b4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      lg_y_ff[0] <= {16'(b4_base_ff[15:0] << nsh), 15'd0};
      lg_frac_ff[0] <= '0;
      lg_n_ff[0] <= nsh;
      lg_cy_ff[0].diff <= b4_cy_ff.diff;
      lg_cy_ff[0].p <= b4_cy_ff.p;
      lg_cy_ff[0].one <= (b4_cy_ff.p == '0) || b4_base_ff[16];
      lg_cy_ff[0].zero <= (b4_base_ff == '0);
      lg_cy_ff[0].degen <= b4_cy_ff.degen;
      lg_cy_ff[0].px <= b4_cy_ff.px;
   end

   // log2 by repeated squaring, one fraction bit a stage
   for (genvar j = 1; j <= LG; j++) begin : g_log
      logic [61:0] ysq;
      assign ysq = lg_y_ff[j-1] * lg_y_ff[j-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            lg_vld_ff[j] <= 1'b0;
         end else begin
            lg_vld_ff[j] <= lg_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ysq[61]) begin
            lg_y_ff[j] <= ysq[61:31];
            lg_frac_ff[j] <= {lg_frac_ff[j-1][14:0], 1'b1};
         end else begin
            lg_y_ff[j] <= ysq[60:30];
            lg_frac_ff[j] <= {lg_frac_ff[j-1][14:0], 1'b0};
         end
         lg_n_ff[j] <= lg_n_ff[j-1];
         lg_cy_ff[j] <= lg_cy_ff[j-1];
      end
   end

   // negated log in q16
   logic        b6_vld_ff;
   logic [20:0] b6_lg_ff;
   cy_type      b6_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b6_vld_ff <= 1'b0;
      end else begin
         b6_vld_ff <= lg_vld_ff[LG];
      end
   end

   always_ff @(posedge clock) begin
      b6_lg_ff <= {5'(lg_n_ff[LG]) + 5'd1, 16'd0} - 21'(lg_frac_ff[LG]);
      b6_cy_ff <= lg_cy_ff[LG];
   end

   // scaled exponent; element 0 of the power chain
   logic        ex_vld_ff [EX+1];
   logic [30:0] ex_acc_ff [EX+1];
   logic [34:0] ex_e_ff [EX+1];
   cy_type      ex_cy_ff [EX+1];
   logic [42:0] pe;

   assign pe = 43'(b6_cy_ff.p * b6_lg_ff) + 43'd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff[0] <= 1'b0;
      end else begin
         ex_vld_ff[0] <= b6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      ex_acc_ff[0] <= 31'd1 << 30;
      ex_e_ff[0] <= pe[42:8];
      ex_cy_ff[0] <= b6_cy_ff;
   end

   // 2^-f, one fraction bit a stage
   for (genvar i = 1; i <= EX; i++) begin : g_exp
      logic [60:0] aprod;
      assign aprod = ex_acc_ff[i-1] * pnms_pkg::EXP_ROOT[i-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            ex_vld_ff[i] <= 1'b0;
         end else begin
            ex_vld_ff[i] <= ex_vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ex_e_ff[i-1][16-i]) begin
            ex_acc_ff[i] <= aprod[60:30];
         end else begin
            ex_acc_ff[i] <= ex_acc_ff[i-1];
         end
         ex_e_ff[i] <= ex_e_ff[i-1];
         ex_cy_ff[i] <= ex_cy_ff[i-1];
      end
   end

   // integer part shift and specular factor
   logic        b8_vld_ff;
   logic [16:0] b8_spec_ff;
   cy_type      b8_cy_ff;
   logic [18:0] kint;
   logic [4:0]  ksh;
   logic [31:0] acc_rnd;
   logic [31:0] acc_sh;

   assign kint = ex_e_ff[EX][34:16];
   assign ksh = kint[4:0];
   assign acc_rnd = 32'(ex_acc_ff[EX]) + (32'd1 << (5'd13 + ksh));
   assign acc_sh = acc_rnd >> (5'd14 + ksh);

   always_ff @(posedge clock) begin
      if (reset) begin
         b8_vld_ff <= 1'b0;
      end else begin
         b8_vld_ff <= ex_vld_ff[EX];
      end
   end

   always_ff @(posedge clock) begin
      if (ex_cy_ff[EX].one) begin
         b8_spec_ff <= 17'h10000;
      end else if (ex_cy_ff[EX].zero || kint > 19'd16) begin
         b8_spec_ff <= '0;
      end else begin
         b8_spec_ff <= acc_sh[16:0];
      end
      b8_cy_ff <= ex_cy_ff[EX];
   end

   // color: ratio products
   logic        c1_vld_ff;
   logic [32:0] c1_ss_ff;
   logic [32:0] c1_dd_ff;
   cy_type      c1_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
      end else begin
         c1_vld_ff <= b8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ss_ff <= sratio * b8_spec_ff;
      c1_dd_ff <= dratio * b8_cy_ff.diff;
      c1_cy_ff <= b8_cy_ff;
   end

   // color: tint products and diffuse weight
   logic        c2_vld_ff;
   logic [48:0] c2_st_ff [3];
   logic [33:0] c2_k1_ff;
   cy_type      c2_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_vld_ff <= 1'b0;
      end else begin
         c2_vld_ff <= c1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         c2_st_ff[i] <= c1_ss_ff * tint[16*i +: 16];
      end
      c2_k1_ff <= 34'({amb, 12'd0}) + 34'(c1_dd_ff);
      c2_cy_ff <= c1_cy_ff;
   end

   // color: base products and times 255
   logic        c3_vld_ff;
   logic [41:0] c3_t1_ff [3];
   logic [56:0] c3_t2_ff [3];
   cy_type      c3_cy_ff;
   logic [7:0]  basec [3];

   assign basec[0] = c2_cy_ff.px.base_red;
   assign basec[1] = c2_cy_ff.px.base_green;
   assign basec[2] = c2_cy_ff.px.base_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_vld_ff <= 1'b0;
      end else begin
         c3_vld_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         c3_t1_ff[i] <= c2_k1_ff * basec[i];
         c3_t2_ff[i] <= {c2_st_ff[i], 8'd0} - 57'(c2_st_ff[i]);
      end
      c3_cy_ff <= c2_cy_ff;
   end

   // sum, round and saturate into the result register
   logic              rsp_valid_ff;
   pnms_pkg::rsp_type rsp_data_ff;
   logic [58:0]       csum [3];
   logic [7:0]        cout [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         csum[i] = 59'({c3_t1_ff[i], 16'd0}) + 59'(c3_t2_ff[i]) + (59'd1 << 39);
         cout[i] = (csum[i][58:48] != '0) ? 8'hff : csum[i][47:40];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.shaded_red <= cout[0];
      rsp_data_ff.shaded_green <= cout[1];
      rsp_data_ff.shaded_blue <= cout[2];
      rsp_data_ff.shaded_alpha <= c3_cy_ff.px.base_alpha;
      rsp_data_ff.normal_degenerate <= c3_cy_ff.degen;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### sv/phong_normal_mapped_shading_unit.sv
// Normal-mapped Phong shading, fully pipelined: one fragment word per clock. Each result
// is on rsp_valid for a single cycle, and results come out in order.
// The depth is set by the bit-per-stage square root and divider that normalize the normal
// and the squaring log and root-product power chains of the specular term. The receiver
// cannot stall, so busy stays low in operation. Csr writes are to be made only while no
// fragment is in flight; the block itself does not enforce this.
module phong_normal_mapped_shading_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  pnms_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output pnms_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [pnms_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  logic [pnms_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [47:0] mrow_x_ff;
   logic [47:0] mrow_y_ff;
   logic [47:0] mrow_z_ff;
   logic [47:0] ldir_ff;
   logic [47:0] tint_ff;
   logic [63:0] blend_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mrow_x_ff <= pnms_pkg::MROW_X_RST;
         mrow_y_ff <= pnms_pkg::MROW_Y_RST;
         mrow_z_ff <= pnms_pkg::MROW_Z_RST;
         ldir_ff <= pnms_pkg::LDIR_RST;
         tint_ff <= pnms_pkg::TINT_RST;
         blend_ff <= pnms_pkg::BLEND_RST;
      end else if (csr_we) begin
         case (csr_idx)
            pnms_pkg::CSR_MROW_X: begin
               mrow_x_ff <= csr_wdata[47:0];
            end
            pnms_pkg::CSR_MROW_Y: begin
               mrow_y_ff <= csr_wdata[47:0];
            end
            pnms_pkg::CSR_MROW_Z: begin
               mrow_z_ff <= csr_wdata[47:0];
            end
            pnms_pkg::CSR_LDIR: begin
               ldir_ff <= csr_wdata[47:0];
            end
            pnms_pkg::CSR_TINT: begin
               tint_ff <= csr_wdata[47:0];
            end
            pnms_pkg::CSR_BLEND: begin
               blend_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   logic              accept;
   logic              geo_valid;
   pnms_pkg::geo_type geo_data;
   logic              lit_valid;
   pnms_pkg::geo_type lit_data;
   logic              q_full;

   assign busy = q_full;
   assign accept = start && !busy;

   // geometry front: normal transform and normalize
   pnms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .mrow_x    (mrow_x_ff),
      .mrow_y    (mrow_y_ff),
      .mrow_z    (mrow_z_ff),
      .out_valid (geo_valid),
      .out_data  (geo_data)
   );

   // word queue between front and back
   pnms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (geo_valid),
      .push_data (geo_data),
      .pop_valid (lit_valid),
      .pop_data  (lit_data),
      .full      (q_full)
   );

   // lighting back: diffuse, specular power, color
   pnms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lit_valid),
      .in_data   (lit_data),
      .ldir      (ldir_ff),
      .tint      (tint_ff),
      .blend     (blend_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/tb_phong_normal_mapped_shading_unit.sv
module tb_phong_normal_mapped_shading_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 95;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pnms_pkg::req_type req_data = '0;
   logic rsp_valid;
   pnms_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [pnms_pkg::CSR_IDX_W-1:0] csr_idx = pnms_pkg::CSR_MROW_X;
   logic [pnms_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;

   always #1 clock = ~clock;

   phong_normal_mapped_shading_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_idx(csr_idx),
      .csr_wdata(csr_wdata)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // fixed point shading predictor
   class shade_scoreboard;
      logic [47:0] mat_row [3];
      logic [47:0] light_dir;
      logic [47:0] light_tint;
      logic [63:0] blend;
      pnms_pkg::rsp_type pending_words [$];

      function new();
         mat_row[0] = pnms_pkg::MROW_X_RST;
         mat_row[1] = pnms_pkg::MROW_Y_RST;
         mat_row[2] = pnms_pkg::MROW_Z_RST;
         light_dir = pnms_pkg::LDIR_RST;
         light_tint = pnms_pkg::TINT_RST;
         blend = pnms_pkg::BLEND_RST;
      endfunction

      function void write_reg(input logic [pnms_pkg::CSR_IDX_W-1:0] idx,
                              input logic [63:0] val);
         case (idx)
            pnms_pkg::CSR_MROW_X: mat_row[0] = val[47:0];
            pnms_pkg::CSR_MROW_Y: mat_row[1] = val[47:0];
            pnms_pkg::CSR_MROW_Z: mat_row[2] = val[47:0];
            pnms_pkg::CSR_LDIR: light_dir = val[47:0];
            pnms_pkg::CSR_TINT: light_tint = val[47:0];
            pnms_pkg::CSR_BLEND: blend = val;
            default: ;
         endcase
      endfunction

      static function longint signed lane_s(input logic [63:0] v, input int i);
         logic signed [15:0] x;
         x = v[16*i +: 16];
         return longint'(x);
      endfunction

      static function longint unsigned lane_u(input logic [63:0] v, input int i);
         return longint'(v[16*i +: 16]);
      endfunction

      static function longint unsigned int_sqrt(input longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // rounded division, halves away from zero
      static function longint signed round_div(input longint signed num,
                                               input longint signed den);
         longint unsigned mag, q;
         mag = num < 0 ? longint'(-num) : num;
         q = (mag * 2 + den) / (2 * den);
         return num < 0 ? -longint'(q) : longint'(q);
      endfunction

      static function longint unsigned neg_log2(input longint unsigned x);
         int n;
         longint unsigned y, frac;
         n = 0;
         frac = 0;
         while ((x << n) < 32768) n++;
         y = (x << n) << 15;
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               frac = frac | 1;
            end
         end
         return (longint'(n + 1) << 16) - frac;
      endfunction

      static function longint unsigned exp2_neg(input longint unsigned e);
         longint unsigned k, f, acc, r;
         k = e >> 16;
         f = e & 16'hFFFF;
         acc = 64'd1 << 30;
         r = 64'd1 << 29;
         if (k > 16) return 0;
         for (int i = 0; i < 16; i++) begin
            if (i > 0) r = int_sqrt(r << 30);
            if ((f >> (15 - i)) & 1) acc = (acc * r) >> 30;
         end
         return (acc + (64'd1 << (13 + k))) >> (14 + k);
      endfunction

      function void note_fragment(input pnms_pkg::req_type px);
         longint signed nrm [3], tv [3], uv [3], lv [3], d, rz;
         longint unsigned len2, len, diff, base, p, spec, k1, t1, t2, sum, v;
         logic [7:0] code [3];
         logic [7:0] col [3];
         pnms_pkg::rsp_type w;
         code[0] = px.normal_red;
         code[1] = px.normal_green;
         code[2] = px.normal_blue;
         col[0] = px.base_red;
         col[1] = px.base_green;
         col[2] = px.base_blue;
         len2 = 0;
         d = 0;
         for (int i = 0; i < 3; i++) begin
            nrm[i] = round_div((2 * longint'(code[i]) - 255) * 4096, 255);
            lv[i] = lane_s(light_dir, i);
            uv[i] = 0;
         end
         for (int i = 0; i < 3; i++) begin
            tv[i] = 0;
            for (int j = 0; j < 3; j++) tv[i] += lane_s(mat_row[i], j) * nrm[j];
            len2 += tv[i] * tv[i];
         end
         len = int_sqrt(len2);
         w.normal_degenerate = (len == 0);
         if (len != 0)
            for (int i = 0; i < 3; i++) uv[i] = round_div(tv[i] * 4096, len);
         for (int i = 0; i < 3; i++) d += uv[i] * lv[i];
         diff = d > 0 ? (longint'(d) + 2048) >> 12 : 0;
         rz = 2 * d * uv[2] - lv[2] * (64'sd1 << 24);
         if (rz <= 0) base = 0;
         else if (rz >= (64'sd1 << 36)) base = 65536;
         else base = (longint'(rz) + (64'd1 << 19)) >> 20;
         p = (longint'(px.specular_level) * lane_u(blend, 3) * 16 + 127) / 255;
         if (p == 0 || base >= 65536) spec = 65536;
         else if (base == 0) spec = 0;
         else spec = exp2_neg((p * neg_log2(base) + 128) >> 8);
         for (int i = 0; i < 3; i++) begin
            k1 = (lane_u(blend, 0) << 12) + lane_u(blend, 1) * diff;
            t1 = k1 * col[i];
            t2 = lane_u(blend, 2) * spec * lane_u(light_tint, i) * 255;
            sum = (t1 << 16) + t2;
            v = (sum + (64'd1 << 39)) >> 40;
            col[i] = v > 255 ? 8'd255 : v[7:0];
         end
         w.shaded_red = col[0];
         w.shaded_green = col[1];
         w.shaded_blue = col[2];
         w.shaded_alpha = px.base_alpha;
         pending_words.push_back(w);
      endfunction

      task check_word(input pnms_pkg::rsp_type got);
         pnms_pkg::rsp_type want;
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", got, 0);
            return;
         end
         want = pending_words.pop_front();
         if (got.shaded_red !== want.shaded_red)
            report_mismatch("shaded_red", got.shaded_red, want.shaded_red);
         if (got.shaded_green !== want.shaded_green)
            report_mismatch("shaded_green", got.shaded_green, want.shaded_green);
         if (got.shaded_blue !== want.shaded_blue)
            report_mismatch("shaded_blue", got.shaded_blue, want.shaded_blue);
         if (got.shaded_alpha !== want.shaded_alpha)
            report_mismatch("shaded_alpha", got.shaded_alpha, want.shaded_alpha);
         if (got.normal_degenerate !== want.normal_degenerate)
            report_mismatch("normal_degenerate", got.normal_degenerate,
                            want.normal_degenerate);
      endtask
   endclass

   shade_scoreboard shade_sb = new();

   // sample accepted inputs and results at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) shade_sb.note_fragment(req_data);
         if (rsp_valid) shade_sb.check_word(rsp_data);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // write one register, then drop the write enable before returning
   task automatic write_csr(input logic [pnms_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] val);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      shade_sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic drain_pipe();
      start <= 1'b0;
      while (shade_sb.pending_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_fragment(input pnms_pkg::req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic pnms_pkg::req_type rand_fragment();
      pnms_pkg::req_type px;
      px = {$urandom, $urandom};
      // bias toward extreme codes now and then
      if ($urandom_range(7) == 0) px.normal_blue = $urandom_range(1) ? 8'd255 : 8'd0;
      if ($urandom_range(7) == 0) px.specular_level = $urandom_range(1) ? 8'd255 : 8'd0;
      return px;
   endfunction

   function automatic logic [47:0] rand_lanes(input int lo, input int hi);
      logic [47:0] v;
      for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($urandom_range(hi) - lo);
      return v;
   endfunction

   // one register setting per phase
   task automatic apply_setting(input int which);
      case (which)
         0: begin
            write_csr(pnms_pkg::CSR_BLEND, {16'h0100, 16'h1000, 16'h1000, 16'h0400});
         end
         1: begin
            write_csr(pnms_pkg::CSR_MROW_X, 48'hFFFF_FFFF_FFFF);
            write_csr(pnms_pkg::CSR_MROW_Y, 48'h7FFF_8000_7FFF);
            write_csr(pnms_pkg::CSR_MROW_Z, 48'h8000_7FFF_8000);
            write_csr(pnms_pkg::CSR_LDIR, 48'h7FFF_8000_7FFF);
            write_csr(pnms_pkg::CSR_TINT, 48'hFFFF_FFFF_FFFF);
            write_csr(pnms_pkg::CSR_BLEND, 64'hFFFF_FFFF_FFFF_FFFF);
         end
         2: begin
            write_csr(pnms_pkg::CSR_MROW_X, 48'h0);
            write_csr(pnms_pkg::CSR_MROW_Y, 48'h0);
            write_csr(pnms_pkg::CSR_MROW_Z, 48'h0);
            write_csr(pnms_pkg::CSR_LDIR, 48'h0);
            write_csr(pnms_pkg::CSR_TINT, 48'h0);
            write_csr(pnms_pkg::CSR_BLEND, 64'h0);
         end
         3: begin
            write_csr(pnms_pkg::CSR_MROW_X, pnms_pkg::MROW_X_RST);
            write_csr(pnms_pkg::CSR_MROW_Y, pnms_pkg::MROW_Y_RST);
            write_csr(pnms_pkg::CSR_MROW_Z, pnms_pkg::MROW_Z_RST);
            write_csr(pnms_pkg::CSR_LDIR, 48'h0B50_0000_0B50);
            write_csr(pnms_pkg::CSR_TINT, 48'h1000_0C00_0800);
            write_csr(pnms_pkg::CSR_BLEND, {16'(16 * $urandom_range(1, 200)), 16'h0C00,
                                            16'h0C00, 16'h0200});
         end
         default: begin
            write_csr(pnms_pkg::CSR_MROW_X, rand_lanes(8192, 16383));
            write_csr(pnms_pkg::CSR_MROW_Y, rand_lanes(8192, 16383));
            write_csr(pnms_pkg::CSR_MROW_Z, rand_lanes(8192, 16383));
            write_csr(pnms_pkg::CSR_LDIR, rand_lanes(4096, 8191));
            write_csr(pnms_pkg::CSR_TINT, 48'($urandom_range(20000))
                                          | {$urandom_range(20000), 16'h0}
                                          | {16'($urandom_range(20000)), 32'h0});
            write_csr(pnms_pkg::CSR_BLEND, {16'($urandom_range(4000)),
                                            16'($urandom_range(8191)),
                                            16'($urandom_range(8191)),
                                            16'($urandom_range(4096))});
         end
      endcase
   endtask

   initial begin
      pnms_pkg::req_type px;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words: reset setting, then lit
      for (int ph = 0; ph < 2; ph++) begin
         if (ph == 1) apply_setting(0);
         px = '0;
         send_fragment(px);
         px = '1;
         send_fragment(px);
         px = {8'd128, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'hA5};
         send_fragment(px);
         // near-zero normal, still non-degenerate by rounding
         px = {8'd127, 8'd128, 8'd127, 8'd0, 8'd10, 8'd20, 8'd30, 8'd40};
         send_fragment(px);
         px = {8'd0, 8'd255, 8'd128, 8'd128, 8'd200, 8'd100, 8'd50, 8'h5A};
         send_fragment(px);
         px = {8'd255, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255};
         send_fragment(px);
         drain_pipe();
      end
      // zero matrix gives degenerate normal; saturating light gives base at one
      for (int s = 1; s <= 2; s++) begin
         apply_setting(s);
         repeat (4) send_fragment(rand_fragment());
         drain_pipe();
      end

      // random phases with idling mixes
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: send_idle_pct = 0;
            1: send_idle_pct = 47;
            2: send_idle_pct = 21;
            default: send_idle_pct = 0;
         endcase
         apply_setting(ph % 3 == 0 ? 3 : 4);
         for (int i = 0; i < 105; i++) begin
            send_fragment(rand_fragment());
            // let the pipe empty once mid-phase
            if (ph == 5 && i == 50) begin
               start <= 1'b0;
               while (shade_sb.pending_words.size() != 0) @(posedge clock);
            end
         end
         drain_pipe();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
